// ===== hdl/token_bucket_packet_shaper_unit_defines.svh =====
// assertion macros for the token bucket packet shaper
// no dependencies; included by the top level only
`ifndef TOKEN_BUCKET_PACKET_SHAPER_UNIT_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TBPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbps check failed");
`define TBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbps check failed");
`else
`define TBPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tbps_pkg.sv =====
// shared types and codes of the token bucket packet shaper
// no dependencies; used by tbps_front, tbps_back and the top level
package tbps_pkg;

    // width of the fixed-size payload fields
    localparam int FIELD_WIDTH = 16;

    // result event codes
    typedef enum logic [2:0] {
        EV_QUEUED        = 3'd0,
        EV_DROP_BIG      = 3'd1,
        EV_DROP_FULL     = 3'd2,
        EV_TOKEN_ADDED   = 3'd3,
        EV_TOKEN_DROPPED = 3'd4,
        EV_RELEASED      = 3'd5
    } event_t;

    // input kinds
    typedef enum logic {
        KIND_PACKET = 1'b0,
        KIND_TICK   = 1'b1
    } kind_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_RELEASE
    } back_state_t;

    // classified command passed from front to back
    typedef struct packed {
        kind_t kind;
        logic  too_big;
    } cmd_ctrl_t;

endpackage

// ===== hdl/tbps_front.sv =====
// front end: accepts input transactions, numbers and classifies them,
// and holds them in a two-entry command queue; depends on tbps_pkg
module tbps_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [tbps_pkg::FIELD_WIDTH-1:0] s_tokens_needed,
    input  logic [tbps_pkg::FIELD_WIDTH-1:0] bucket_depth,
    output logic                             cmd_valid,
    input  logic                             cmd_pop,
    output tbps_pkg::cmd_ctrl_t              cmd_ctrl,
    output logic [tbps_pkg::FIELD_WIDTH-1:0] cmd_need,
    output logic [COUNT_WIDTH-1:0]           cmd_num
);

    tbps_pkg::cmd_ctrl_t              q_ctrl_reg [2];
    logic [tbps_pkg::FIELD_WIDTH-1:0] q_need_reg [2];
    logic [COUNT_WIDTH-1:0]           q_num_reg  [2];

    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic [COUNT_WIDTH-1:0] next_number_reg, next_number_next;
    logic [COUNT_WIDTH-1:0] num_inc;
    logic                   push, pop, is_packet;
    tbps_pkg::cmd_ctrl_t    new_ctrl;

    // handshake and classification
    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign is_packet = (tbps_pkg::kind_t'(s_kind) == tbps_pkg::KIND_PACKET);

    always_comb begin
        new_ctrl.kind    = tbps_pkg::kind_t'(s_kind);
        new_ctrl.too_big = is_packet && (s_tokens_needed > bucket_depth);
    end

    // numbering wraps past zero, which stays reserved for token events
    assign num_inc = next_number_reg + 1'b1;

    always_comb begin
        next_number_next = next_number_reg;
        if (push && is_packet) begin
            next_number_next = (num_inc == '0) ? COUNT_WIDTH'(1) : num_inc;
        end
    end

    // queue pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= 2'd0;
            next_number_reg <= COUNT_WIDTH'(1);
        end else begin
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
            next_number_reg <= next_number_next;
        end
    end

    // queue payload, ticks carry number zero
    always_ff @(posedge aclk) begin
        if (push) begin
            q_ctrl_reg[wr_ptr_reg] <= new_ctrl;
            q_need_reg[wr_ptr_reg] <= s_tokens_needed;
            q_num_reg[wr_ptr_reg]  <= is_packet ? next_number_reg : '0;
        end
    end

    assign cmd_ctrl = q_ctrl_reg[rd_ptr_reg];
    assign cmd_need = q_need_reg[rd_ptr_reg];
    assign cmd_num  = q_num_reg[rd_ptr_reg];

endmodule

// ===== hdl/tbps_back.sv =====
// back end: bucket level, waiting memory and release sequencer with
// the result output register; depends on tbps_pkg
module tbps_back #(
    parameter int QUEUE_DEPTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [tbps_pkg::FIELD_WIDTH-1:0] bucket_depth,
    input  logic                             cmd_valid,
    output logic                             cmd_pop,
    input  tbps_pkg::cmd_ctrl_t              cmd_ctrl,
    input  logic [tbps_pkg::FIELD_WIDTH-1:0] cmd_need,
    input  logic [COUNT_WIDTH-1:0]           cmd_num,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_event_res,
    output logic [tbps_pkg::FIELD_WIDTH-1:0] m_packet_number,
    output logic [tbps_pkg::FIELD_WIDTH-1:0] m_tokens_held,
    output logic                             m_last
);

    localparam int FW = tbps_pkg::FIELD_WIDTH;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int OW = QW + 1;
    localparam int LW = ((COUNT_WIDTH > FW) ? COUNT_WIDTH : FW) + 1;
    localparam int WW = COUNT_WIDTH + FW;

    // waiting memory: packet number over need
    logic [WW-1:0] mem [QUEUE_DEPTH];
    logic [WW-1:0] rd_word_reg;
    logic          wr_en;

    tbps_pkg::back_state_t  state_reg, state_next;
    logic [COUNT_WIDTH-1:0] level_reg, level_next;
    logic [QW-1:0]          head_reg, head_next;
    logic [QW-1:0]          tail_reg, tail_next;
    logic [OW-1:0]          occ_reg, occ_next;
    tbps_pkg::event_t       pend_ev_reg, pend_ev_next;
    logic [COUNT_WIDTH-1:0] pend_num_reg, pend_num_next;
    logic [COUNT_WIDTH-1:0] pend_lvl_reg, pend_lvl_next;
    logic                   out_valid_reg, out_valid_next;
    tbps_pkg::event_t       out_ev_reg, out_ev_next;
    logic [FW-1:0]          out_num_reg, out_num_next;
    logic [FW-1:0]          out_lvl_reg, out_lvl_next;
    logic                   out_last_reg, out_last_next;

    logic                   push_ok, load, fits, tick_over;
    tbps_pkg::event_t       src_ev;
    logic [COUNT_WIDTH-1:0] src_num, src_lvl;
    logic                   src_last;
    logic [LW-1:0]          src_num_wide, src_lvl_wide;
    logic [FW-1:0]          rd_need;
    logic [COUNT_WIDTH-1:0] rd_num;
    logic [LW-1:0]          rel_wide;
    logic [COUNT_WIDTH-1:0] rel_level;
    logic [QW-1:0]          head_adv, tail_adv;

    // head entry fields and bucket arithmetic
    assign rd_need   = rd_word_reg[FW-1:0];
    assign rd_num    = rd_word_reg[WW-1:FW];
    assign fits      = (occ_reg != '0) && (LW'(rd_need) <= LW'(level_reg));
    assign tick_over = (LW'(level_reg) + LW'(1)) > LW'(bucket_depth);
    assign rel_wide  = LW'(level_reg) - LW'(rd_need);
    assign rel_level = rel_wide[COUNT_WIDTH-1:0];
    assign head_adv  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_adv  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign push_ok   = !out_valid_reg || m_ready;

    // sequencer: outcome, head read, decide, release
    always_comb begin
        state_next    = state_reg;
        level_next    = level_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        pend_ev_next  = pend_ev_reg;
        pend_num_next = pend_num_reg;
        pend_lvl_next = pend_lvl_reg;
        cmd_pop       = 1'b0;
        wr_en         = 1'b0;
        load          = 1'b0;
        src_ev        = pend_ev_reg;
        src_num       = pend_num_reg;
        src_lvl       = pend_lvl_reg;
        src_last      = 1'b1;
        unique case (state_reg)
            tbps_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    state_next = tbps_pkg::ST_READ;
                    if (cmd_ctrl.kind == tbps_pkg::KIND_PACKET) begin
                        pend_num_next = cmd_num;
                        pend_lvl_next = level_reg;
                        if (cmd_ctrl.too_big) begin
                            pend_ev_next = tbps_pkg::EV_DROP_BIG;
                        end else if (occ_reg == OW'(QUEUE_DEPTH)) begin
                            pend_ev_next = tbps_pkg::EV_DROP_FULL;
                        end else begin
                            wr_en        = 1'b1;
                            tail_next    = tail_adv;
                            occ_next     = occ_reg + 1'b1;
                            pend_ev_next = tbps_pkg::EV_QUEUED;
                        end
                    end else begin
                        pend_num_next = '0;
                        if (tick_over) begin
                            pend_ev_next  = tbps_pkg::EV_TOKEN_DROPPED;
                            pend_lvl_next = level_reg;
                        end else begin
                            level_next    = level_reg + 1'b1;
                            pend_ev_next  = tbps_pkg::EV_TOKEN_ADDED;
                            pend_lvl_next = level_reg + 1'b1;
                        end
                    end
                end
            end
            tbps_pkg::ST_READ: begin
                state_next = tbps_pkg::ST_DECIDE;
            end
            tbps_pkg::ST_DECIDE: begin
                if (push_ok) begin
                    load       = 1'b1;
                    src_last   = !fits;
                    state_next = fits ? tbps_pkg::ST_RELEASE : tbps_pkg::ST_IDLE;
                end
            end
            tbps_pkg::ST_RELEASE: begin
                if (push_ok) begin
                    load       = 1'b1;
                    src_ev     = tbps_pkg::EV_RELEASED;
                    src_num    = rd_num;
                    src_lvl    = rel_level;
                    level_next = rel_level;
                    head_next  = head_adv;
                    occ_next   = occ_reg - 1'b1;
                    state_next = tbps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbps_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    assign src_num_wide = LW'(src_num);
    assign src_lvl_wide = LW'(src_lvl);

    always_comb begin
        out_ev_next    = out_ev_reg;
        out_num_next   = out_num_reg;
        out_lvl_next   = out_lvl_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_ev_next    = src_ev;
            out_num_next   = src_num_wide[FW-1:0];
            out_lvl_next   = src_lvl_wide[FW-1:0];
            out_last_next  = src_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tbps_pkg::ST_IDLE;
            level_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_ev_reg  <= pend_ev_next;
        pend_num_reg <= pend_num_next;
        pend_lvl_reg <= pend_lvl_next;
        out_ev_reg   <= out_ev_next;
        out_num_reg  <= out_num_next;
        out_lvl_reg  <= out_lvl_next;
        out_last_reg <= out_last_next;
    end

    // waiting memory, registered read at the head
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= {cmd_num, cmd_need};
        end
        rd_word_reg <= mem[head_reg];
    end

    assign m_valid         = out_valid_reg;
    assign m_event_res     = out_ev_reg;
    assign m_packet_number = out_num_reg;
    assign m_tokens_held   = out_lvl_reg;
    assign m_last          = out_last_reg;

endmodule

// ===== hdl/token_bucket_packet_shaper_unit.sv =====
// top level of the token bucket packet shaper: bucket depth register,
// front end and back end; depends on tbps_pkg, tbps_front, tbps_back
//
//  channel  prefix  direction  payload
//  input    s_      in         kind, tokens_needed
//  result   m_      out        event_res, packet_number, tokens_held, last
//  config   cfg_    in         bucket_depth (one register, no index)
//
// an input transaction passes through the back end sequencer steps outcome, head read from the
// waiting memory, decide and, when the head packet fits the bucket, release; the steps come from the
// back end sequencer and the registered read port of the waiting memory.
// reset is synchronous and clears all control state; the waiting memory is not cleared.
// a two-entry command queue lets the input side keep accepting until it is full while the output stalls.
`include "token_bucket_packet_shaper_unit_defines.svh"
module token_bucket_packet_shaper_unit #(
    parameter int QUEUE_DEPTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_tokens_needed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [15:0] m_packet_number,
    output logic [15:0] m_tokens_held,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_bucket_depth
);

    logic [tbps_pkg::FIELD_WIDTH-1:0] depth_reg, depth_next;
    logic                             cmd_valid, cmd_pop;
    tbps_pkg::cmd_ctrl_t              cmd_ctrl;
    logic [tbps_pkg::FIELD_WIDTH-1:0] cmd_need;
    logic [COUNT_WIDTH-1:0]           cmd_num;

    // bucket depth register
    assign cfg_ready  = 1'b1;
    assign depth_next = (cfg_valid && cfg_ready) ? cfg_bucket_depth : depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= 16'd10;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // front end
    tbps_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_tokens_needed (s_tokens_needed),
        .bucket_depth    (depth_reg),
        .cmd_valid       (cmd_valid),
        .cmd_pop         (cmd_pop),
        .cmd_ctrl        (cmd_ctrl),
        .cmd_need        (cmd_need),
        .cmd_num         (cmd_num)
    );

    // back end
    tbps_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .bucket_depth    (depth_reg),
        .cmd_valid       (cmd_valid),
        .cmd_pop         (cmd_pop),
        .cmd_ctrl        (cmd_ctrl),
        .cmd_need        (cmd_need),
        .cmd_num         (cmd_num),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_packet_number (m_packet_number),
        .m_tokens_held   (m_tokens_held),
        .m_last          (m_last)
    );

    // back end only takes commands that the front end holds
    `TBPS_ASSERT_SAME(a_pop_valid, aclk, aresetn, cmd_pop, cmd_valid)
    // an outcome without last is followed at once by its release
    `TBPS_ASSERT_NEXT(a_release_follows, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_last && (m_event_res == tbps_pkg::EV_RELEASED))
    // token events carry packet number zero
    `TBPS_ASSERT_SAME(a_token_number, aclk, aresetn, m_valid && ((m_event_res == tbps_pkg::EV_TOKEN_ADDED) || (m_event_res == tbps_pkg::EV_TOKEN_DROPPED)), m_packet_number == 16'd0)

endmodule
